### design/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is switched off while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### design/pllpi_pkg.sv
package pllpi_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INT_GAIN   = 3'd1;
	localparam logic [2:0] REG_AW_GAIN    = 3'd2;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
	localparam logic [2:0] REG_FREQ_MAX   = 3'd4;
	localparam logic [2:0] REG_FREQ_MIN   = 3'd5;
	localparam logic [2:0] REG_PERIOD     = 3'd6;
	localparam logic [2:0] REG_OFFSET     = 3'd7;

	localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               clear;
		logic signed [31:0] phase_error;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] frequency;
		logic [29:0]        raw_angle;
		logic [29:0]        angle;
	} result_t;

	// Saturate a wide signed value into 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
		logic signed [31:0] r;
		if (x > 35'(S32_MAX)) begin
			r = S32_MAX;
		end else if (x < 35'(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Q16.16 product rescale: floor of product over 2^16, saturated to 32 bits.
	function automatic logic signed [31:0] q16_scale(input logic signed [66:0] p);
		logic signed [31:0] r;
		if ((p[66:47] == '0) || (p[66:47] == '1)) begin
			r = p[47:16];
		end else if (p[66]) begin
			r = S32_MIN;
		end else begin
			r = S32_MAX;
		end
		return r;
	endfunction

endpackage

### design/pll_pid_phase_integrator.sv
// Channel  | Dir | Handshake                  | Word
// sample   | in  | sample_valid/sample_ready  | pllpi_pkg::sample_t (clear, phase_error)
// result   | out | result_valid/result_ready  | pllpi_pkg::result_t (frequency, raw/angle)
// cfg      | in  | cfg_we (no wait)           | cfg_index selects, cfg_data carries value
//
// A normal word passes five times through the single 33x34 bit multiplier
// (proportional, anti-windup, integral, derivative, phase step), then through
// a clamp step and a write-back step; a word is accepted only in the idle step.
// A word with clear set goes from idle straight to write-back.
// Reset loads the register defaults and clears all loop state at once; no sweep.
// An untaken result holds the next word in write-back until the slot is free.
`include "assert_macros.svh"

module pll_pid_phase_integrator #(
	parameter int INTEGRATOR_MODE = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  pllpi_pkg::sample_t   sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output pllpi_pkg::result_t   result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	// Sequencer steps. Each multiplier step loads the shared product register.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROP  = 3'd1;
	localparam logic [2:0] ST_AW    = 3'd2;
	localparam logic [2:0] ST_INT   = 3'd3;
	localparam logic [2:0] ST_DER   = 3'd4;
	localparam logic [2:0] ST_FREQ  = 3'd5;
	localparam logic [2:0] ST_PHASE = 3'd6;
	localparam logic [2:0] ST_WB    = 3'd7;

	// Any mode other than forward or backward Euler behaves as trapezoidal.
	localparam bit MODE_FWD  = (INTEGRATOR_MODE == 0);
	localparam bit MODE_BWD  = (INTEGRATOR_MODE == 1);
	localparam bit MODE_TRAP = !MODE_FWD && !MODE_BWD;

	logic [2:0] state_q;

	// Configuration registers.
	logic signed [31:0] prop_gain_q, int_gain_q, aw_gain_q, deriv_gain_q;
	logic signed [31:0] freq_max_q, freq_min_q;
	logic [31:0]        period_q;
	logic [29:0]        offset_q;

	// Loop state.
	logic signed [31:0] integral_q, last_prop_q, sat_error_q, last_freq_q, freq_q;
	logic [29:0]        phase_acc_q;

	// Working registers of the current word.
	logic               clear_q;
	logic signed [31:0] err_q, up_q, aw_term_q;
	logic signed [66:0] prod_q;
	logic               result_valid_q;
	pllpi_pkg::result_t result_q;

	// Shared multiplier operands.
	logic signed [32:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [66:0] mul_p;

	logic signed [32:0] prop_diff;
	logic signed [32:0] freq_sum;
	logic signed [31:0] scaled;
	logic signed [34:0] int_sum;
	logic signed [34:0] raw_sum;
	logic signed [34:0] freq_lim;
	logic signed [31:0] freq_new;
	logic [29:0]        delta;
	logic [29:0]        phase_new;
	logic               wb_go;

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign wb_go        = (state_q == ST_WB) && (!result_valid_q || result_ready);

	assign prop_diff = 33'(up_q) - 33'(last_prop_q);
	assign freq_sum  = 33'(freq_q) + 33'(last_freq_q);
	assign scaled    = pllpi_pkg::q16_scale(prod_q);

	always_comb begin
		unique case (state_q)
			ST_IDLE, ST_PROP: begin
				mul_a = 33'(prop_gain_q);
				mul_b = 34'(err_q);
			end
			ST_AW: begin
				mul_a = 33'(aw_gain_q);
				mul_b = 34'(sat_error_q);
			end
			ST_INT: begin
				mul_a = 33'(int_gain_q);
				mul_b = 34'(up_q);
			end
			ST_DER: begin
				mul_a = 33'(deriv_gain_q);
				mul_b = 34'(prop_diff);
			end
			ST_FREQ, ST_PHASE, ST_WB: begin
				// Sample period is unsigned; a zero top bit keeps it positive.
				mul_a = {1'b0, period_q};
				if (MODE_FWD) begin
					mul_b = 34'(last_freq_q);
				end else if (MODE_BWD) begin
					mul_b = 34'(freq_q);
				end else begin
					mul_b = 34'(freq_sum);
				end
			end
		endcase
	end

	assign mul_p = 67'(mul_a) * 67'(mul_b);

	// Regulator arithmetic that follows each rescaled product.
	always_comb begin
		int_sum  = 35'(integral_q) + 35'(scaled) + 35'(aw_term_q);
		raw_sum  = 35'(up_q) + 35'(integral_q) + 35'(scaled);
		freq_lim = raw_sum;
		if (freq_lim > 35'(freq_max_q)) begin
			freq_lim = 35'(freq_max_q);
		end
		if (freq_lim < 35'(freq_min_q)) begin
			freq_lim = 35'(freq_min_q);
		end
		freq_new = freq_lim[31:0];
	end

	// Phase step: bits of the modular product, taken one position higher for the
	// trapezoidal rule since it sums two samples and halves them.
	always_comb begin
		if (MODE_TRAP) begin
			delta = prod_q[48:19];
		end else begin
			delta = prod_q[47:18];
		end
		phase_new = phase_acc_q + delta;
	end

	// Control, configuration and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			prop_gain_q    <= pllpi_pkg::Q16_ONE;
			int_gain_q     <= '0;
			aw_gain_q      <= '0;
			deriv_gain_q   <= '0;
			freq_max_q     <= pllpi_pkg::S32_MAX;
			freq_min_q     <= pllpi_pkg::S32_MIN;
			period_q       <= '0;
			offset_q       <= '0;
			integral_q     <= '0;
			last_prop_q    <= '0;
			sat_error_q    <= '0;
			last_freq_q    <= '0;
			freq_q         <= '0;
			phase_acc_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pllpi_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
					pllpi_pkg::REG_INT_GAIN:   int_gain_q   <= cfg_data;
					pllpi_pkg::REG_AW_GAIN:    aw_gain_q    <= cfg_data;
					pllpi_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
					pllpi_pkg::REG_FREQ_MAX:   freq_max_q   <= cfg_data;
					pllpi_pkg::REG_FREQ_MIN:   freq_min_q   <= cfg_data;
					pllpi_pkg::REG_PERIOD:     period_q     <= cfg_data;
					pllpi_pkg::REG_OFFSET:     offset_q     <= cfg_data[29:0];
				endcase
			end

			// A new result may land in the same cycle as the old one is taken.
			if (wb_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= sample.clear ? ST_WB : ST_PROP;
					end
				end
				ST_PROP:  state_q <= ST_AW;
				ST_AW:    state_q <= ST_INT;
				ST_INT:   state_q <= ST_DER;
				ST_DER: begin
					integral_q <= pllpi_pkg::sat32(int_sum);
					state_q    <= ST_FREQ;
				end
				ST_FREQ: begin
					freq_q      <= freq_new;
					sat_error_q <= pllpi_pkg::sat32(freq_lim - raw_sum);
					last_prop_q <= up_q;
					state_q     <= ST_PHASE;
				end
				ST_PHASE: state_q <= ST_WB;
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
						if (clear_q) begin
							// The saturation error survives a clear.
							integral_q  <= '0;
							last_prop_q <= '0;
							phase_acc_q <= '0;
							last_freq_q <= '0;
						end else begin
							phase_acc_q <= phase_new;
							if (!MODE_BWD) begin
								last_freq_q <= freq_q;
							end
						end
					end
				end
			endcase
		end
	end

	// Working data of the current word.
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			clear_q <= sample.clear;
			err_q   <= sample.phase_error;
		end
		if (state_q == ST_AW) begin
			up_q <= scaled;
		end
		if (state_q == ST_INT) begin
			aw_term_q <= scaled;
		end
		if ((state_q != ST_IDLE) && (state_q != ST_FREQ) && (state_q != ST_WB)) begin
			prod_q <= mul_p;
		end else if (state_q == ST_FREQ) begin
			// Derivative product is consumed this cycle; the phase product needs the new
			// frequency outside forward Euler mode, so it is formed in the phase step.
			prod_q <= prod_q;
		end
		if (wb_go) begin
			if (clear_q) begin
				result_q <= '0;
			end else begin
				result_q.frequency <= freq_q;
				result_q.raw_angle <= phase_new;
				result_q.angle     <= phase_new + offset_q;
			end
		end
	end

	`ASSERT_NEXT(a_one_word_at_a_time, sample_valid && sample_ready, !sample_ready,
		"sequencer accepted a second word while busy")
	`ASSERT_IMPL(a_raw_angle_tracks_acc, result_valid_q && (state_q == ST_IDLE),
		result_q.raw_angle == phase_acc_q, "raw angle differs from phase accumulator")
	`ASSERT_NEXT(a_writeback_leaves, wb_go, (state_q == ST_IDLE) && result_valid_q,
		"write-back did not deliver a result")

endmodule
